@@ design/bpac_pkg.sv @@
`default_nettype none

package bpac_pkg;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_PUSH    = 3'd1,
        CMD_REST    = 3'd2,
        CMD_RESTART = 3'd3,
        CMD_SAMPLE  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        REG_PUSH_SECONDS     = 3'd0,
        REG_MIN_PUSH_SECONDS = 3'd1,
        REG_PUSH_ANGLE       = 3'd2,
        REG_REST_ANGLE       = 3'd3,
        REG_ON_THRESHOLD     = 3'd4,
        REG_ON_WHEN_ABOVE    = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        LED_OFF  = 2'd0,
        LED_ON   = 2'd1,
        LED_NONE = 2'd2
    } led_state_t;

    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int SAMPLE_W = 12;
    localparam int HOLD_W   = 18;
    localparam int TIME_W   = 32;

    localparam logic [7:0]          PUSH_SECONDS_RST     = 8'd1;
    localparam logic [7:0]          MIN_PUSH_SECONDS_RST = 8'd1;
    localparam logic [7:0]          PUSH_ANGLE_RST       = 8'd90;
    localparam logic [7:0]          REST_ANGLE_RST       = 8'd0;
    localparam logic [SAMPLE_W-1:0] ON_THRESHOLD_RST     = 12'd2048;
    localparam logic                ON_WHEN_ABOVE_RST    = 1'b1;
    localparam logic [HOLD_W-1:0]   HOLD_RST             = 18'd1000;
    localparam logic [HOLD_W-1:0]   MS_PER_SECOND        = 18'd1000;

    typedef struct packed {
        logic [7:0]          push_seconds;
        logic [7:0]          min_push_seconds;
        logic [7:0]          push_angle;
        logic [7:0]          rest_angle;
        logic [SAMPLE_W-1:0] on_threshold;
        logic                on_when_above;
    } cfg_t;

    typedef struct packed {
        logic [7:0] servo_angle;
        logic       holding;
        logic       push_accepted;
        logic       restart_due;
    } press_status_t;

    typedef struct packed {
        logic power_on;
        logic led_changed;
    } led_status_t;

endpackage

`default_nettype wire

@@ design/bpac_cfg_regs.sv @@
`default_nettype none

module bpac_cfg_regs
    import bpac_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_PUSH_SECONDS:     cfg_next.push_seconds     = pwdata[7:0];
                REG_MIN_PUSH_SECONDS: cfg_next.min_push_seconds = pwdata[7:0];
                REG_PUSH_ANGLE:       cfg_next.push_angle       = pwdata[7:0];
                REG_REST_ANGLE:       cfg_next.rest_angle       = pwdata[7:0];
                REG_ON_THRESHOLD:     cfg_next.on_threshold     = pwdata[SAMPLE_W-1:0];
                REG_ON_WHEN_ABOVE:    cfg_next.on_when_above    = pwdata[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PUSH_SECONDS:     prdata = {24'd0, cfg_reg.push_seconds};
            REG_MIN_PUSH_SECONDS: prdata = {24'd0, cfg_reg.min_push_seconds};
            REG_PUSH_ANGLE:       prdata = {24'd0, cfg_reg.push_angle};
            REG_REST_ANGLE:       prdata = {24'd0, cfg_reg.rest_angle};
            REG_ON_THRESHOLD:     prdata = {20'd0, cfg_reg.on_threshold};
            REG_ON_WHEN_ABOVE:    prdata = {31'd0, cfg_reg.on_when_above};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.push_seconds     <= PUSH_SECONDS_RST;
            cfg_reg.min_push_seconds <= MIN_PUSH_SECONDS_RST;
            cfg_reg.push_angle       <= PUSH_ANGLE_RST;
            cfg_reg.rest_angle       <= REST_ANGLE_RST;
            cfg_reg.on_threshold     <= ON_THRESHOLD_RST;
            cfg_reg.on_when_above    <= ON_WHEN_ABOVE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ design/bpac_press_ctrl.sv @@
`default_nettype none

module bpac_press_ctrl
    import bpac_pkg::*;
#(
    parameter int RESTART_DELAY_MS = 800
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  fire,
    input  wire cmd_t  cmd,
    input  wire cfg_t  cfg,
    output press_status_t status
);

    logic [TIME_W-1:0] time_reg, time_next;
    logic              push_pending_reg, push_pending_next;
    logic              rest_pending_reg, rest_pending_next;
    logic              press_active_reg, press_active_next;
    logic              release_armed_reg, release_armed_next;
    logic [TIME_W-1:0] press_start_reg, press_start_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic [7:0]        angle_reg, angle_next;
    logic              restart_pending_reg, restart_pending_next;
    logic [TIME_W-1:0] deadline_reg, deadline_next;

    logic [7:0]        secs;
    logic [HOLD_W-1:0] hold_calc;
    logic [TIME_W-1:0] time_inc;
    logic [TIME_W-1:0] to_deadline;
    logic [TIME_W-1:0] elapsed;
    logic              start_press;
    logic              accepted;
    logic              due;

    assign secs      = (cfg.push_seconds < cfg.min_push_seconds) ? cfg.min_push_seconds
                                                                 : cfg.push_seconds;
    assign hold_calc = HOLD_W'({10'd0, secs} * MS_PER_SECOND);
    assign time_inc  = time_reg + TIME_W'(1);
    assign to_deadline = time_inc - deadline_reg;

    always_comb
    begin
        time_next            = time_reg;
        push_pending_next    = push_pending_reg;
        rest_pending_next    = rest_pending_reg;
        press_active_next    = press_active_reg;
        release_armed_next   = release_armed_reg;
        press_start_next     = press_start_reg;
        hold_next            = hold_reg;
        angle_next           = angle_reg;
        restart_pending_next = restart_pending_reg;
        deadline_next        = deadline_reg;
        start_press          = 1'b0;
        accepted             = 1'b0;
        due                  = 1'b0;
        elapsed              = '0;

        if (fire)
        begin
            case (cmd)
                CMD_TICK:
                begin
                    time_next = time_inc;
                    if (restart_pending_reg && !to_deadline[TIME_W-1])
                    begin
                        due                  = 1'b1;
                        restart_pending_next = 1'b0;
                    end
                    if (push_pending_reg && !press_active_reg)
                    begin
                        start_press        = 1'b1;
                        push_pending_next  = 1'b0;
                        press_active_next  = 1'b1;
                        hold_next          = hold_calc;
                        angle_next         = cfg.push_angle;
                        release_armed_next = 1'b1;
                        press_start_next   = time_inc;
                    end
                    else if (rest_pending_reg && !press_active_reg)
                    begin
                        rest_pending_next = 1'b0;
                        angle_next        = cfg.rest_angle;
                    end
                    // a press started on this tick has zero elapsed time
                    elapsed = start_press ? '0 : (time_inc - press_start_reg);
                    if (release_armed_next && (elapsed >= {14'd0, hold_next}))
                    begin
                        angle_next         = cfg.rest_angle;
                        press_active_next  = 1'b0;
                        release_armed_next = 1'b0;
                    end
                end
                CMD_PUSH:
                begin
                    if (!press_active_reg && !push_pending_reg)
                    begin
                        push_pending_next = 1'b1;
                        accepted          = 1'b1;
                    end
                end
                CMD_REST:
                begin
                    rest_pending_next = 1'b1;
                end
                CMD_RESTART:
                begin
                    if (!restart_pending_reg)
                    begin
                        restart_pending_next = 1'b1;
                        deadline_next        = time_reg + TIME_W'(RESTART_DELAY_MS);
                    end
                end
                default:
                begin
                end
            endcase
        end

        status.servo_angle   = angle_next;
        status.holding       = press_active_next;
        status.push_accepted = accepted;
        status.restart_due   = due;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg            <= '0;
            push_pending_reg    <= 1'b0;
            rest_pending_reg    <= 1'b0;
            press_active_reg    <= 1'b0;
            release_armed_reg   <= 1'b0;
            press_start_reg     <= '0;
            hold_reg            <= HOLD_RST;
            angle_reg           <= REST_ANGLE_RST;
            restart_pending_reg <= 1'b0;
            deadline_reg        <= '0;
        end
        else
        begin
            time_reg            <= time_next;
            push_pending_reg    <= push_pending_next;
            rest_pending_reg    <= rest_pending_next;
            press_active_reg    <= press_active_next;
            release_armed_reg   <= release_armed_next;
            press_start_reg     <= press_start_next;
            hold_reg            <= hold_next;
            angle_reg           <= angle_next;
            restart_pending_reg <= restart_pending_next;
            deadline_reg        <= deadline_next;
        end
    end

endmodule

`default_nettype wire

@@ design/bpac_led_qual.sv @@
`default_nettype none

module bpac_led_qual
    import bpac_pkg::*;
#(
    parameter int QUALIFY_SAMPLES = 3
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire cmd_t                cmd,
    input  wire logic [SAMPLE_W-1:0] sample,
    input  wire cfg_t                cfg,
    output led_status_t              status
);

    localparam int CNT_W = $clog2(QUALIFY_SAMPLES + 1);

    led_state_t       cand_reg, cand_next;
    led_state_t       qual_reg, qual_next;
    logic [CNT_W-1:0] count_reg, count_next;
    led_state_t       cls;
    logic             changed;

    always_comb
    begin
        if (cfg.on_when_above)
            cls = (sample >= cfg.on_threshold) ? LED_ON : LED_OFF;
        else
            cls = (sample <= cfg.on_threshold) ? LED_ON : LED_OFF;
    end

    always_comb
    begin
        cand_next  = cand_reg;
        qual_next  = qual_reg;
        count_next = count_reg;
        changed    = 1'b0;
        if (fire && (cmd == CMD_SAMPLE))
        begin
            if (cls != cand_reg)
            begin
                cand_next  = cls;
                count_next = CNT_W'(1);
            end
            else if (count_reg < CNT_W'(QUALIFY_SAMPLES))
            begin
                count_next = count_reg + CNT_W'(1);
            end
            if ((count_next >= CNT_W'(QUALIFY_SAMPLES)) && (cand_next != qual_reg))
            begin
                qual_next = cand_next;
                changed   = 1'b1;
            end
        end
        status.power_on    = (qual_next == LED_ON);
        status.led_changed = changed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg  <= LED_NONE;
            qual_reg  <= LED_NONE;
            count_reg <= '0;
        end
        else
        begin
            cand_reg  <= cand_next;
            qual_reg  <= qual_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ design/button_press_actuator_controller.sv @@
// Servo power-button presser with power-LED watcher.
// Input stream (s_*): one command per transfer, kind in s_tuser (0 tick of 1 ms,
// 1 push, 2 rest, 3 restart, 4 sensor sample), the 12-bit sample in s_tdata.
// Output stream (m_*): exactly one status transfer per input transfer, in order:
// servo angle, holding, power on, push accepted, restart due, LED changed.
// Configuration via the APB port: hold seconds, minimum hold, push and rest
// angles, LED threshold and polarity; write only while the streams are idle.
// Pipeline: an input transfer enters the input register, then its result the result
// register, which drives m_*. Throughput: one item per cycle while m_tready is not
// held low; all state is updated as the item moves from the input register to the
// result register.
// Reset: asynchronous, active low; servo at rest angle 0, no press queued,
// clock 0, LED state unknown, registers at their defaults.
// Stall: a result waiting on m_tready holds; one more item is still taken into
// the input register, after which s_tready drops until the result is taken.
`default_nettype none

module button_press_actuator_controller
    import bpac_pkg::*;
#(
    parameter int QUALIFY_SAMPLES  = 3,
    parameter int RESTART_DELAY_MS = 800
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,   // [11:0] sensor_sample
    input  wire logic [2:0]        s_tuser,   // [2:0] command
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [15:0]       m_tdata,   // [7:0] servo_angle, [8] holding,
                                              // [9] power_on, [10] push_accepted,
                                              // [11] restart_due, [12] led_changed
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    cfg_t                cfg;
    press_status_t       press_st;
    led_status_t         led_st;

    logic                in_valid_reg;
    cmd_t                in_cmd_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic                out_valid_reg;
    logic [15:0]         out_data_reg;
    logic                advance;
    logic                fire;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    bpac_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bpac_press_ctrl #(
        .RESTART_DELAY_MS (RESTART_DELAY_MS)
    ) u_press
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .cmd    (in_cmd_reg),
        .cfg    (cfg),
        .status (press_st)
    );

    bpac_led_qual #(
        .QUALIFY_SAMPLES (QUALIFY_SAMPLES)
    ) u_led
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .cmd    (in_cmd_reg),
        .sample (in_sample_reg),
        .cfg    (cfg),
        .status (led_st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg    <= cmd_t'(s_tuser);
            in_sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
        if (fire)
        begin
            out_data_reg <= {3'd0, led_st.led_changed, press_st.restart_due,
                             press_st.push_accepted, led_st.power_on,
                             press_st.holding, press_st.servo_angle};
        end
    end

    // accepted push only while no press is running
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg[10] |-> !out_data_reg[8])
        else $error("push accepted while holding");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && (in_cmd_reg != CMD_TICK) |=> !out_data_reg[11])
        else $error("restart due outside a tick");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && (in_cmd_reg != CMD_SAMPLE) |=> !out_data_reg[12])
        else $error("led change outside a sample");

    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

@@ tb/tb_button_press_actuator_controller.sv @@
`default_nettype none

module tb_button_press_actuator_controller;
    import bpac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUALIFY_RUN   = 3;
    localparam int RESTART_MS    = 800;
    localparam int DRAIN_PAUSE   = 4;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS   = 80;

    // commands the block ignores
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    typedef struct {
        logic [7:0] angle;
        logic       holding;
        logic       power_on;
        logic       accepted;
        logic       due;
        logic       changed;
    } status_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata = '0;    // [11:0] sensor_sample
    logic [2:0]        s_tuser = '0;    // [2:0] command
    logic              m_tvalid;
    logic              m_tready = 1'b1;
    logic [15:0]       m_tdata;         // [7:0] servo_angle, [8] holding, [9] power_on,
                                        // [10] push_accepted, [11] restart_due,
                                        // [12] led_changed
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    button_press_actuator_controller #(
        .QUALIFY_SAMPLES (QUALIFY_RUN),
        .RESTART_DELAY_MS(RESTART_MS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    // controller copy kept by the bench
    cfg_t        ctl_cfg;
    logic [31:0] now_ms;
    logic        push_queued;
    logic        rest_queued;
    logic        pressing;
    logic        release_due;
    logic [31:0] press_began_ms;
    logic [17:0] hold_ms;
    logic [7:0]  servo_now;
    logic        restart_armed;
    logic [31:0] restart_at_ms;
    led_state_t  led_cand;
    int          led_run;
    led_state_t  led_qual;

    status_t pending_status_q[$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      cycles = 0;
    int      tx_max_gap = 0;
    int      rx_max_stall = 0;
    int      rx_hold_req = 0;
    logic [11:0] sample_run = '0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %0s: got %0d want %0d at result %0d", what, got, want, results_seen);
        mismatches++;
    endtask

    task automatic advance_controller(input logic [2:0] cmd, input logic [11:0] smp,
                                      output status_t st);
        logic        is_on;
        led_state_t  cls;
        logic [7:0]  secs;
        logic [31:0] to_deadline;
        st.accepted = 1'b0;
        st.due      = 1'b0;
        st.changed  = 1'b0;
        case (cmd)
            CMD_TICK:
            begin
                now_ms = now_ms + 32'd1;
                to_deadline = now_ms - restart_at_ms;
                if (restart_armed && !to_deadline[31]) begin
                    st.due = 1'b1;
                    restart_armed = 1'b0;
                end
                if (push_queued && !pressing) begin
                    secs = (ctl_cfg.push_seconds < ctl_cfg.min_push_seconds) ?
                           ctl_cfg.min_push_seconds : ctl_cfg.push_seconds;
                    push_queued    = 1'b0;
                    pressing       = 1'b1;
                    hold_ms        = 18'(int'(secs) * 1000);
                    servo_now      = ctl_cfg.push_angle;
                    release_due    = 1'b1;
                    press_began_ms = now_ms;
                end
                else if (rest_queued && !pressing) begin
                    rest_queued = 1'b0;
                    servo_now   = ctl_cfg.rest_angle;
                end
                if (release_due && (now_ms - press_began_ms) >= {14'd0, hold_ms}) begin
                    servo_now   = ctl_cfg.rest_angle;
                    pressing    = 1'b0;
                    release_due = 1'b0;
                end
            end
            CMD_PUSH:
            begin
                if (!pressing && !push_queued) begin
                    push_queued = 1'b1;
                    st.accepted = 1'b1;
                end
            end
            CMD_REST:
                rest_queued = 1'b1;
            CMD_RESTART:
            begin
                if (!restart_armed) begin
                    restart_armed = 1'b1;
                    restart_at_ms = now_ms + 32'(RESTART_MS);
                end
            end
            CMD_SAMPLE:
            begin
                is_on = ctl_cfg.on_when_above ? (smp >= ctl_cfg.on_threshold) :
                                                (smp <= ctl_cfg.on_threshold);
                cls = is_on ? LED_ON : LED_OFF;
                if (cls != led_cand) begin
                    led_cand = cls;
                    led_run  = 1;
                end
                else if (led_run < QUALIFY_RUN) begin
                    led_run++;
                end
                if (led_run >= QUALIFY_RUN && led_cand != led_qual) begin
                    led_qual   = led_cand;
                    st.changed = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        st.angle    = servo_now;
        st.holding  = pressing;
        st.power_on = (led_qual == LED_ON);
    endtask

    initial
    begin
        ctl_cfg.push_seconds     = PUSH_SECONDS_RST;
        ctl_cfg.min_push_seconds = MIN_PUSH_SECONDS_RST;
        ctl_cfg.push_angle       = PUSH_ANGLE_RST;
        ctl_cfg.rest_angle       = REST_ANGLE_RST;
        ctl_cfg.on_threshold     = ON_THRESHOLD_RST;
        ctl_cfg.on_when_above    = ON_WHEN_ABOVE_RST;
        now_ms         = '0;
        push_queued    = 1'b0;
        rest_queued    = 1'b0;
        pressing       = 1'b0;
        release_due    = 1'b0;
        press_began_ms = '0;
        hold_ms        = HOLD_RST;
        servo_now      = REST_ANGLE_RST;
        restart_armed  = 1'b0;
        restart_at_ms  = '0;
        led_cand       = LED_NONE;
        led_run        = 0;
        led_qual       = LED_NONE;
    end

    // scoreboard: results checked against the oldest prediction, then new transfers predicted
    always @(posedge clk)
    begin
        status_t want;
        status_t fresh;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pending_status_q.size() == 0) begin
                    report_mismatch("unexpected result", int'(m_tdata), 0);
                end
                else begin
                    want = pending_status_q.pop_front();
                    if (m_tdata[7:0] !== want.angle)
                        report_mismatch("servo_angle", int'(m_tdata[7:0]), int'(want.angle));
                    if (m_tdata[8] !== want.holding)
                        report_mismatch("holding", int'(m_tdata[8]), int'(want.holding));
                    if (m_tdata[9] !== want.power_on)
                        report_mismatch("power_on", int'(m_tdata[9]), int'(want.power_on));
                    if (m_tdata[10] !== want.accepted)
                        report_mismatch("push_accepted", int'(m_tdata[10]), int'(want.accepted));
                    if (m_tdata[11] !== want.due)
                        report_mismatch("restart_due", int'(m_tdata[11]), int'(want.due));
                    if (m_tdata[12] !== want.changed)
                        report_mismatch("led_changed", int'(m_tdata[12]), int'(want.changed));
                end
            end
            if (s_tvalid && s_tready) begin
                advance_controller(s_tuser, s_tdata[11:0], fresh);
                pending_status_q.push_back(fresh);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // result side: one stall draw per transfer, or a long hold-off on request
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever begin
            if (rx_hold_req != 0) begin
                stall = rx_hold_req;
                rx_hold_req = 0;
            end
            else begin
                stall = $urandom_range(0, rx_max_stall);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                m_tready <= 1'b1;
            end
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_item(input logic [2:0] cmd, input logic [11:0] smp);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'd0, smp};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(CMD_TICK, 12'($urandom_range(0, 4095)));
    endtask

    task automatic send_samples(input logic [11:0] smp, input int count);
        repeat (count) send_item(CMD_SAMPLE, smp);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_status_q.size() != 0) @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_PUSH_SECONDS:     ctl_cfg.push_seconds     = val[7:0];
            REG_MIN_PUSH_SECONDS: ctl_cfg.min_push_seconds = val[7:0];
            REG_PUSH_ANGLE:       ctl_cfg.push_angle       = val[7:0];
            REG_REST_ANGLE:       ctl_cfg.rest_angle       = val[7:0];
            REG_ON_THRESHOLD:     ctl_cfg.on_threshold     = val[SAMPLE_W-1:0];
            REG_ON_WHEN_ABOVE:    ctl_cfg.on_when_above    = val[0];
            default:
            begin
            end
        endcase
    endtask

    task automatic set_config(input int push_s, input int min_s, input int push_a,
                              input int rest_a, input int thr, input int above);
        wait_drained();
        write_reg(REG_PUSH_SECONDS, DATA_W'(push_s));
        write_reg(REG_MIN_PUSH_SECONDS, DATA_W'(min_s));
        write_reg(REG_PUSH_ANGLE, DATA_W'(push_a));
        write_reg(REG_REST_ANGLE, DATA_W'(rest_a));
        write_reg(REG_ON_THRESHOLD, DATA_W'(thr));
        write_reg(REG_ON_WHEN_ABOVE, DATA_W'(above));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_directed_cases();
        tx_max_gap   = 19;
        rx_max_stall = 19;
        send_item(CMD_SAMPLE, 12'd4095);
        send_item(CMD_SAMPLE, 12'd2048);    // level equal to threshold counts as on
        send_item(CMD_SAMPLE, 12'd2047);
        send_samples(12'd0, 3);             // first qualification out of unknown
        send_samples(12'd4095, 3);
        send_item(CMD_PUSH, 12'd0);
        send_item(CMD_PUSH, 12'hFFF);       // already queued
        send_item(CMD_REST, 12'hAAA);
        send_item(CMD_RESTART, 12'h555);
        send_item(CMD_RESTART, 12'd0);      // ignored while armed
        send_item(CMD_TICK, 12'hFFF);       // queued push wins over queued rest
        send_item(CMD_PUSH, 12'd1);         // busy pressing
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            send_item(3'(c), 12'($urandom_range(0, 4095)));
        send_item(CMD_TICK, 12'd0);
    endtask

    task automatic test_press_timing();
        tx_max_gap   = 0;
        rx_max_stall = 0;
        // default hold of one second, deadline and queued rest run out along the way
        send_ticks(1005);
    endtask

    task automatic test_zero_hold();
        tx_max_gap   = 19;
        rx_max_stall = 19;
        set_config(0, 0, 255, 0, 2048, 1);
        send_item(CMD_PUSH, 12'd0);
        send_item(CMD_TICK, 12'd0);         // press and release on one tick
        send_item(CMD_REST, 12'd0);
        send_item(CMD_TICK, 12'd0);
        send_item(CMD_PUSH, 12'd0);
        send_item(CMD_PUSH, 12'd0);
        send_item(CMD_TICK, 12'd0);
    endtask

    task automatic test_led_polarity();
        set_config(1, 1, 90, 0, 0, 0);
        send_samples(12'd0, 3);
        send_samples(12'd1, 3);
        set_config(1, 1, 90, 0, 4095, 1);
        send_samples(12'd4095, 3);
        send_samples(12'd4094, 3);
        set_config(1, 1, 90, 0, 4095, 0);
        send_samples(12'd4095, 2);
        send_samples(12'd0, 1);
        set_config(1, 1, 90, 0, 0, 1);
        send_samples(12'd0, 3);
        send_item(CMD_SAMPLE, 12'd2731);
        send_item(CMD_SAMPLE, 12'd1364);
    endtask

    task automatic test_back_pressure();
        set_config(0, 0, 45, 10, 2048, 1);
        wait_drained();
        tx_max_gap   = 0;
        rx_max_stall = 0;
        rx_hold_req  = 300;
        repeat (40) random_item();
    endtask

    task automatic random_item();
        int pick;
        logic [11:0] smp;
        if ($urandom_range(0, 39) == 0) tx_max_gap = (tx_max_gap == 0) ? 19 : 0;
        if ($urandom_range(0, 39) == 0) rx_max_stall = (rx_max_stall == 0) ? 19 : 0;
        pick = $urandom_range(0, 99);
        smp  = 12'($urandom_range(0, 4095));
        if (pick < 55) begin
            send_item(CMD_TICK, smp);
        end
        else if (pick < 65) begin
            send_item(CMD_PUSH, smp);
        end
        else if (pick < 72) begin
            send_item(CMD_REST, smp);
        end
        else if (pick < 78) begin
            send_item(CMD_RESTART, smp);
        end
        else if (pick < 95) begin
            // runs of one level so that the LED state qualifies now and then
            if ($urandom_range(0, 4) == 0)
                sample_run = ($urandom_range(0, 3) == 0) ?
                             ($urandom_range(0, 1) ? 12'd4095 : 12'd0) :
                             12'($urandom_range(0, 4095));
            if ($urandom_range(0, 3) != 0) smp = sample_run;
            send_item(CMD_SAMPLE, smp);
        end
        else begin
            send_item(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), smp);
        end
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_config(($urandom_range(0, 3) == 0) ? 1 : 0,
                       ($urandom_range(0, 3) == 0) ? 1 : 0,
                       (p == 0) ? 180 : $urandom_range(0, 255),
                       (p == 1) ? 180 : $urandom_range(0, 255),
                       (p == 0) ? 0 : ((p == 1) ? 4095 : $urandom_range(0, 4095)),
                       $urandom_range(0, 1));
            tx_max_gap   = $urandom_range(0, 1) ? 19 : 0;
            rx_max_stall = $urandom_range(0, 1) ? 19 : 0;
            repeat (PHASE_ITEMS) random_item();
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_press_timing();
        test_zero_hold();
        test_led_polarity();
        test_back_pressure();
        test_random_phases();
        wait_drained();
        repeat (10) @(posedge clk);
        if (pending_status_q.size() != 0)
            report_mismatch("results missing", 0, pending_status_q.size());
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
design/bpac_pkg.sv
design/bpac_cfg_regs.sv
design/bpac_press_ctrl.sv
design/bpac_led_qual.sv
design/button_press_actuator_controller.sv
tb/tb_button_press_actuator_controller.sv
